@@ design/cubic_bezier_segment_generator_assert.svh @@
// Assertion macros for the cubic Bezier segment generator datapath.
// Each macro expects the signals clk and rst_n in the enclosing module.
`ifndef CUBIC_BEZIER_SEGMENT_GENERATOR_ASSERT_SVH
`define CUBIC_BEZIER_SEGMENT_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBSG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBSG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/cbsg_pkg.sv @@
// Package for the cubic Bezier segment generator: widths, operation codes and
// the command and status structures between controller and datapath. No dependencies.
package cbsg_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int COORD_W          = 16;
    localparam int SEG_IN_W         = 7;
    localparam int CFG_IDX_W        = 4;
    localparam int NUM_REGS         = 8;
    localparam int T_W              = 17;
    localparam logic [T_W-1:0] ONE_Q16 = 17'h10000;
    localparam int DIV_STEPS        = T_W;
    localparam int SEQ_CNT_W        = $clog2(DIV_STEPS);
    localparam int UU_W             = 33;
    localparam int W_W              = 17;
    localparam int MUL_A_W          = 34;
    localparam int MUL_B_W          = 18;
    localparam int PROD_W           = MUL_A_W + MUL_B_W;
    localparam int ACC_W            = 34;
    localparam int FRAC_LSB         = 32;

    typedef enum logic [3:0] {
        OP_UU   = 4'd0,
        OP_TT   = 4'd1,
        OP_UUU  = 4'd2,
        OP_UUT  = 4'd3,
        OP_UTT  = 4'd4,
        OP_TTT  = 4'd5,
        OP_X0   = 4'd6,
        OP_X1   = 4'd7,
        OP_X2   = 4'd8,
        OP_X3   = 4'd9,
        OP_Y0   = 4'd10,
        OP_Y1   = 4'd11,
        OP_Y2   = 4'd12,
        OP_Y3   = 4'd13,
        OP_FIN  = 4'd14,
        OP_NONE = 4'd15
    } op_t;

    typedef struct packed {
        logic load;
        logic div_step;
        op_t  op;
        logic advance;
        logic shift_prev;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic first;
        logic last;
        logic out_free;
    } status_t;

endpackage

@@ design/cubic_bezier_segment_generator.sv @@
// Top level of the cubic Bezier segment generator; joins controller and datapath.
// Depends on cbsg_pkg, cbsg_ctrl and cbsg_datapath.
//
// A request on the input channel (in_valid, in_stall, segment_count) asks for N
// line segments along the curve set by the eight control point registers. The
// registers are written through cfg_valid, cfg_ready, cfg_index and cfg_data;
// the user must write them only while the block is idle, and the block itself
// does not enforce this. cfg_ready is always high and writes to indexes beyond
// the eighth are ignored. A count of zero is taken and yields nothing; a count
// above MAX_SEGMENTS is treated as MAX_SEGMENTS. Each result transaction
// carries one segment with start and end points and a flag on the last segment
// of the request. After acceptance, a one-bit-per-cycle divider finds the
// parameter step; each curve point is then formed by the single shared
// multiplier, which forms 14 products per point. One request is in work at a
// time: in_stall is high from acceptance until the last result is loaded into
// the output register. A stalled receiver holds the result register and pauses
// the sequence before the next segment is loaded. Reset clears the control
// point registers to zero and returns the block to idle.
module cubic_bezier_segment_generator #(
    parameter int MAX_SEGMENTS = cbsg_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [cbsg_pkg::SEG_IN_W-1:0]        segment_count,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [cbsg_pkg::COORD_W-1:0]  start_x,
    output logic signed [cbsg_pkg::COORD_W-1:0]  start_y,
    output logic signed [cbsg_pkg::COORD_W-1:0]  end_x,
    output logic signed [cbsg_pkg::COORD_W-1:0]  end_y,
    output logic                                 last_segment,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cbsg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cbsg_pkg::COORD_W-1:0]         cfg_data
);
    import cbsg_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    cbsg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    cbsg_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .segment_count (segment_count),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .last_segment  (last_segment)
    );

endmodule

@@ design/cbsg_ctrl.sv @@
// Controller of the cubic Bezier segment generator: sequences division, the
// per-point multiply schedule and result hand-off. Depends on cbsg_pkg.
module cbsg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  cbsg_pkg::status_t status,
    output cbsg_pkg::cmd_t    cmd
);
    import cbsg_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_EVAL  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_POINT = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [SEQ_CNT_W-1:0]   cnt_reg, cnt_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd.load       = 1'b0;
        cmd.div_step   = 1'b0;
        cmd.op         = OP_NONE;
        cmd.advance    = 1'b0;
        cmd.shift_prev = 1'b0;
        cmd.emit       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !status.count_zero)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == SEQ_CNT_W'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_EVAL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EVAL:
            begin
                cmd.op = op_t'(cnt_reg[3:0]);
                if (cnt_reg[3:0] == OP_FIN)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_POINT;
            end
            ST_POINT:
            begin
                if (status.first)
                begin
                    cmd.shift_prev = 1'b1;
                    cmd.advance    = 1'b1;
                    state_next     = ST_EVAL;
                end
                else if (status.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.shift_prev = 1'b1;
                    if (status.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_EVAL;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ design/cbsg_datapath.sv @@
// Datapath of the cubic Bezier segment generator: control point registers,
// parameter divider, shared multiplier, accumulator and output register.
// Depends on cbsg_pkg and cubic_bezier_segment_generator_assert.svh.
`include "cubic_bezier_segment_generator_assert.svh"

module cbsg_datapath #(
    parameter int MAX_SEGMENTS = cbsg_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  cbsg_pkg::cmd_t                          cmd,
    output cbsg_pkg::status_t                       status,
    input  logic [cbsg_pkg::SEG_IN_W-1:0]           segment_count,
    input  logic                                    cfg_we,
    input  logic [cbsg_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [cbsg_pkg::COORD_W-1:0]            cfg_data,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [cbsg_pkg::COORD_W-1:0]     start_x,
    output logic signed [cbsg_pkg::COORD_W-1:0]     start_y,
    output logic signed [cbsg_pkg::COORD_W-1:0]     end_x,
    output logic signed [cbsg_pkg::COORD_W-1:0]     end_y,
    output logic                                    last_segment
);
    import cbsg_pkg::*;

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    logic signed [COORD_W-1:0] cfg_reg [NUM_REGS];

    logic [CNT_W-1:0]   n_reg, seg_reg, rem_reg, frac_reg;
    logic [T_W-1:0]     num_reg, q_reg, t_reg;
    logic [UU_W-1:0]    uu_reg, tt_reg;
    logic [W_W-1:0]     w_reg [4];
    logic signed [PROD_W-1:0]  p_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg, cur_x_reg, cur_y_reg;
    op_t                wb_op_reg;
    logic               out_valid_reg;

    logic [SEG_IN_W-1:0]       n_sat;
    logic [T_W-1:0]            u;
    logic [CNT_W:0]            div_shift, frac_sum, seg_inc;
    logic                      div_ge, frac_carry;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]         p_triple;
    logic signed [ACC_W-1:0]   acc_bias;
    logic signed [COORD_W-1:0] acc_coord;

    assign n_sat = (segment_count > SEG_IN_W'(MAX_SEGMENTS)) ?
                   SEG_IN_W'(MAX_SEGMENTS) : segment_count;
    assign u     = ONE_Q16 - t_reg;

    assign div_shift  = {rem_reg, num_reg[T_W-1]};
    assign div_ge     = (div_shift >= {1'b0, n_reg});
    assign frac_sum   = {1'b0, frac_reg} + {1'b0, rem_reg};
    assign frac_carry = (frac_sum >= {1'b0, n_reg});
    assign seg_inc    = {1'b0, seg_reg} + 1'b1;

    assign status.count_zero = (segment_count == '0);
    assign status.first      = (seg_reg == '0);
    assign status.last       = (seg_reg == n_reg);
    assign status.out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_UU:
            begin
                mul_a = MUL_A_W'(u);
                mul_b = MUL_B_W'(u);
            end
            OP_TT:
            begin
                mul_a = MUL_A_W'(t_reg);
                mul_b = MUL_B_W'(t_reg);
            end
            OP_UUU:
            begin
                mul_a = MUL_A_W'(uu_reg);
                mul_b = MUL_B_W'(u);
            end
            OP_UUT:
            begin
                mul_a = MUL_A_W'(uu_reg);
                mul_b = MUL_B_W'(t_reg);
            end
            OP_UTT:
            begin
                mul_a = MUL_A_W'(tt_reg);
                mul_b = MUL_B_W'(u);
            end
            OP_TTT:
            begin
                mul_a = MUL_A_W'(tt_reg);
                mul_b = MUL_B_W'(t_reg);
            end
            OP_X0:
            begin
                mul_a = MUL_A_W'(cfg_reg[0]);
                mul_b = MUL_B_W'(w_reg[0]);
            end
            OP_X1:
            begin
                mul_a = MUL_A_W'(cfg_reg[2]);
                mul_b = MUL_B_W'(w_reg[1]);
            end
            OP_X2:
            begin
                mul_a = MUL_A_W'(cfg_reg[4]);
                mul_b = MUL_B_W'(w_reg[2]);
            end
            OP_X3:
            begin
                mul_a = MUL_A_W'(cfg_reg[6]);
                mul_b = MUL_B_W'(w_reg[3]);
            end
            OP_Y0:
            begin
                mul_a = MUL_A_W'(cfg_reg[1]);
                mul_b = MUL_B_W'(w_reg[0]);
            end
            OP_Y1:
            begin
                mul_a = MUL_A_W'(cfg_reg[3]);
                mul_b = MUL_B_W'(w_reg[1]);
            end
            OP_Y2:
            begin
                mul_a = MUL_A_W'(cfg_reg[5]);
                mul_b = MUL_B_W'(w_reg[2]);
            end
            OP_Y3:
            begin
                mul_a = MUL_A_W'(cfg_reg[7]);
                mul_b = MUL_B_W'(w_reg[3]);
            end
            OP_FIN, OP_NONE:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign p_triple = {p_reg[PROD_W-2:0], 1'b0} + p_reg;

    // Division by 65536 truncates toward zero, so negative sums are biased first.
    assign acc_bias  = acc_reg + (acc_reg[ACC_W-1] ? ACC_W'(16'hFFFF) : ACC_W'(0));
    assign acc_coord = acc_bias[2*COORD_W-1:COORD_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_REGS; k++)
            begin
                cfg_reg[k] <= '0;
            end
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS)))
        begin
            cfg_reg[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_op_reg     <= OP_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wb_op_reg <= cmd.op;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= prod;

        if (cmd.load)
        begin
            n_reg    <= CNT_W'(n_sat);
            num_reg  <= ONE_Q16;
            rem_reg  <= '0;
            q_reg    <= '0;
            t_reg    <= '0;
            frac_reg <= '0;
            seg_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[T_W-2:0], 1'b0};
            q_reg   <= {q_reg[T_W-2:0], div_ge};
            rem_reg <= div_ge ? CNT_W'(div_shift - {1'b0, n_reg}) : CNT_W'(div_shift);
        end
        else if (cmd.advance)
        begin
            t_reg    <= t_reg + q_reg + T_W'(frac_carry);
            frac_reg <= frac_carry ? CNT_W'(frac_sum - {1'b0, n_reg}) : CNT_W'(frac_sum);
            seg_reg  <= CNT_W'(seg_inc);
        end

        unique case (wb_op_reg)
            OP_UU:  uu_reg   <= p_reg[UU_W-1:0];
            OP_TT:  tt_reg   <= p_reg[UU_W-1:0];
            OP_UUU: w_reg[0] <= p_reg[FRAC_LSB+W_W-1:FRAC_LSB];
            OP_UUT: w_reg[1] <= p_triple[FRAC_LSB+W_W-1:FRAC_LSB];
            OP_UTT: w_reg[2] <= p_triple[FRAC_LSB+W_W-1:FRAC_LSB];
            OP_TTT: w_reg[3] <= p_reg[FRAC_LSB+W_W-1:FRAC_LSB];
            OP_X0:  acc_reg  <= p_reg[ACC_W-1:0];
            OP_X1, OP_X2, OP_X3, OP_Y1, OP_Y2, OP_Y3:
            begin
                acc_reg <= acc_reg + p_reg[ACC_W-1:0];
            end
            OP_Y0:
            begin
                cur_x_reg <= acc_coord;
                acc_reg   <= p_reg[ACC_W-1:0];
            end
            OP_FIN: cur_y_reg <= acc_coord;
            OP_NONE:
            begin
            end
            default:
            begin
            end
        endcase

        if (cmd.shift_prev)
        begin
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
        end

        if (cmd.emit)
        begin
            start_x      <= prev_x_reg;
            start_y      <= prev_y_reg;
            end_x        <= cur_x_reg;
            end_y        <= cur_y_reg;
            last_segment <= (seg_reg == n_reg);
        end
    end

    assign out_valid = out_valid_reg;

    `CBSG_ASSERT_IMP(a_no_overrun, cmd.advance && !status.first, seg_reg != n_reg,
        "Parameter advanced beyond the final segment.")
    `CBSG_ASSERT_IMP(a_frac_bound, cmd.advance, (frac_reg < n_reg) && (rem_reg < n_reg),
        "Parameter remainder out of range.")
    `CBSG_ASSERT_NXT(a_end_at_one, cmd.advance && (seg_inc == {1'b0, n_reg}),
        t_reg == ONE_Q16, "Final parameter does not reach one.")
    `CBSG_ASSERT_IMP(a_no_overwrite, cmd.emit, !out_valid_reg || !out_stall,
        "Result register overwritten while stalled.")

endmodule
